@@ rtl/circuit_breaker_degradation_macros.svh @@
// assertion macros for the breaker checker
`ifndef CIRCUIT_BREAKER_DEGRADATION_MACROS_SVH
`define CIRCUIT_BREAKER_DEGRADATION_MACROS_SVH

// same-cycle implication, off during reset
`define CBD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("circuit breaker assertion failed");

// next-cycle implication, off during reset
`define CBD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("circuit breaker assertion failed");

// next-cycle implication, active through reset
`define CBD_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("circuit breaker reset assertion failed");

`endif

@@ rtl/cbd_pkg.sv @@
`default_nettype none

package cbd_pkg;

   localparam int TIME_BITS = 48;
   localparam int RUN_BITS  = 16;
   localparam int CNT_BITS  = 32;
   localparam int TMO_BITS  = 32;
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   typedef logic [TIME_BITS-1:0] stamp_type;
   typedef logic [RUN_BITS-1:0]  run_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   typedef enum logic [1:0] {
      BRK_CLOSED = 2'd0,
      BRK_HALF   = 2'd1,
      BRK_OPEN   = 2'd2
   } breaker_type;

   typedef enum logic [2:0] {
      LVL_NONE       = 3'd0,
      LVL_READ_ONLY  = 3'd1,
      LVL_STALE      = 3'd2,
      LVL_CACHE_ONLY = 3'd3,
      LVL_OFFLINE    = 3'd4
   } level_type;

   typedef enum logic [2:0] {
      OP_SUCCESS     = 3'd0,
      OP_FAILURE     = 3'd1,
      OP_FORCE_OPEN  = 3'd2,
      OP_FORCE_CLOSE = 3'd3,
      OP_RECOVER     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      RR_RECOVERED   = 2'd0,
      RR_DEGRADED    = 2'd1,
      RR_NOT_ATTEMPT = 2'd2
   } rres_type;

   typedef enum logic [1:0] {
      REG_FAIL_TH    = 2'd0,
      REG_SUCC_TH    = 2'd1,
      REG_OPEN_TMO   = 2'd2
   } reg_type;

   typedef struct packed {
      run_type             fail_th;
      run_type             succ_th;
      logic [TMO_BITS-1:0] open_tmo;
   } cfg_type;

   typedef struct packed {
      logic [2:0] op;
      stamp_type  now;
      logic       cache;
   } item_type;

   typedef struct packed {
      breaker_type breaker;
      level_type   level;
      run_type     fail_cnt;
      run_type     succ_cnt;
      stamp_type   opened_time;
      stamp_type   degrade_start;
      count_type   trip_cnt;
      count_type   rec_cnt;
      count_type   att_cnt;
      stamp_type   degraded_total;
   } state_type;

   typedef struct packed {
      breaker_type breaker;
      level_type   level;
      logic        level_changed;
      level_type   prev_level;
      run_type     fail_run;
      run_type     succ_run;
      rres_type    rres;
      count_type   trip_total;
      count_type   rec_total;
      count_type   att_total;
      stamp_type   degraded_time;
   } result_type;

   function automatic run_type sat_inc(input run_type v);
      sat_inc = (v == {RUN_BITS{1'b1}}) ? v : v + run_type'(1);
   endfunction

endpackage

`default_nettype wire

@@ rtl/cbd_next.sv @@
`default_nettype none

module cbd_next (
   input  cbd_pkg::state_type  cur,
   input  cbd_pkg::item_type   item,
   input  cbd_pkg::cfg_type    cfg,
   output cbd_pkg::state_type  nxt,
   output cbd_pkg::result_type res
);

   cbd_pkg::run_type     fc_inc;
   cbd_pkg::run_type     sc_inc;
   cbd_pkg::stamp_type   elapsed;
   logic                 timeout_ok;
   logic                 open_now;
   logic                 relevel;
   cbd_pkg::level_type   target;
   cbd_pkg::rres_type    rres;

   assign fc_inc     = cbd_pkg::sat_inc(cur.fail_cnt);
   assign sc_inc     = cbd_pkg::sat_inc(cur.succ_cnt);
   assign elapsed    = item.now - cur.opened_time;
   assign timeout_ok = elapsed >= cbd_pkg::stamp_type'(cfg.open_tmo);

   always_comb begin
      nxt      = cur;
      open_now = 1'b0;
      relevel  = 1'b0;
      rres     = cbd_pkg::RR_NOT_ATTEMPT;
      target   = cbd_pkg::LVL_NONE;

      case (cbd_pkg::op_type'(item.op))
         cbd_pkg::OP_SUCCESS: begin
            nxt.fail_cnt = '0;
            if (cur.breaker == cbd_pkg::BRK_HALF) begin
               nxt.succ_cnt = sc_inc;
               if (sc_inc >= cfg.succ_th) begin
                  nxt.breaker  = cbd_pkg::BRK_CLOSED;
                  nxt.succ_cnt = '0;
                  nxt.rec_cnt  = cur.rec_cnt + cbd_pkg::count_type'(1);
                  relevel      = 1'b1;
               end
            end
         end
         cbd_pkg::OP_FAILURE: begin
            nxt.fail_cnt = fc_inc;
            nxt.succ_cnt = '0;
            if (cur.breaker == cbd_pkg::BRK_CLOSED) begin
               if (fc_inc >= cfg.fail_th) begin
                  open_now     = 1'b1;
                  nxt.trip_cnt = cur.trip_cnt + cbd_pkg::count_type'(1);
               end
            end else if (cur.breaker == cbd_pkg::BRK_HALF) begin
               open_now = 1'b1;
            end else if (timeout_ok) begin
               nxt.breaker = cbd_pkg::BRK_HALF;
               relevel     = 1'b1;
            end
         end
         cbd_pkg::OP_FORCE_OPEN: begin
            if (cur.breaker != cbd_pkg::BRK_OPEN) begin
               open_now     = 1'b1;
               nxt.trip_cnt = cur.trip_cnt + cbd_pkg::count_type'(1);
            end
         end
         cbd_pkg::OP_FORCE_CLOSE: begin
            nxt.breaker  = cbd_pkg::BRK_CLOSED;
            nxt.fail_cnt = '0;
            nxt.succ_cnt = '0;
            nxt.rec_cnt  = cur.rec_cnt + cbd_pkg::count_type'(1);
            relevel      = 1'b1;
         end
         cbd_pkg::OP_RECOVER: begin
            nxt.att_cnt = cur.att_cnt + cbd_pkg::count_type'(1);
            if (cur.breaker == cbd_pkg::BRK_OPEN && timeout_ok) begin
               nxt.breaker  = cbd_pkg::BRK_HALF;
               nxt.succ_cnt = '0;
               relevel      = 1'b1;
               rres         = cbd_pkg::RR_DEGRADED;
            end else if (cur.breaker == cbd_pkg::BRK_CLOSED) begin
               rres = cbd_pkg::RR_RECOVERED;
            end else begin
               rres = cbd_pkg::RR_DEGRADED;
            end
         end
         default: begin
         end
      endcase

      if (open_now) begin
         nxt.breaker     = cbd_pkg::BRK_OPEN;
         nxt.opened_time = item.now;
         relevel         = 1'b1;
      end

      case (nxt.breaker)
         cbd_pkg::BRK_CLOSED: target = cbd_pkg::LVL_NONE;
         cbd_pkg::BRK_HALF:   target = cbd_pkg::LVL_READ_ONLY;
         default: target = item.cache ? cbd_pkg::LVL_CACHE_ONLY : cbd_pkg::LVL_OFFLINE;
      endcase

      if (relevel && target != cur.level) begin
         if (target != cbd_pkg::LVL_NONE && cur.level == cbd_pkg::LVL_NONE) begin
            nxt.degrade_start = item.now;
         end else if (target == cbd_pkg::LVL_NONE && cur.level != cbd_pkg::LVL_NONE) begin
            nxt.degraded_total = cur.degraded_total + (item.now - cur.degrade_start);
         end
         nxt.level = target;
      end

      res.breaker       = nxt.breaker;
      res.level         = nxt.level;
      res.level_changed = nxt.level != cur.level;
      res.prev_level    = cur.level;
      res.fail_run      = nxt.fail_cnt;
      res.succ_run      = nxt.succ_cnt;
      res.rres          = rres;
      res.trip_total    = nxt.trip_cnt;
      res.rec_total     = nxt.rec_cnt;
      res.att_total     = nxt.att_cnt;
      res.degraded_time = nxt.degraded_total;
   end

endmodule

`default_nettype wire

@@ rtl/circuit_breaker_degradation.sv @@
// three-state circuit breaker with degradation level
// req channel: one event per item (op, now_ms, cache_has_entries), valid/ready
// rsp channel: one result item per event, valid/ready, in event order
// csr port: apb-style, trip failure count at 0x0, close success count at 0x4,
//   open timeout in ms at 0x8; pready is always high, reads return the register
// an accepted item sits in the input register until the output register is free or
//   rsp_ready is high; its result is then loaded into the output register, which
//   drives rsp_valid, so a result passes the input and then the output register
// throughput is one item per clock unless the output stalls; the next-state logic
//   is a single pass of compares, subtracts, adds and increments between the two registers
// while rsp_ready is low the result holds and one more item can be taken into
//   the input register; req_ready then drops until the output drains
// reset (synchronous, active high) empties both registers, closes the breaker,
//   sets level none, clears all counters and times and loads 5, 3 and 30000
//   into the three configuration registers
`default_nettype none

module circuit_breaker_degradation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [2:0]                           req_op,
   input  logic [cbd_pkg::TIME_BITS-1:0]        req_now_ms,
   input  logic                                 req_cache_has_entries,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_breaker_state,
   output logic [2:0]                           rsp_level,
   output logic                                 rsp_level_changed,
   output logic [2:0]                           rsp_previous_level,
   output logic [cbd_pkg::RUN_BITS-1:0]         rsp_fail_run,
   output logic [cbd_pkg::RUN_BITS-1:0]         rsp_success_run,
   output logic [1:0]                           rsp_recovery_result,
   output logic [cbd_pkg::CNT_BITS-1:0]         rsp_trip_total,
   output logic [cbd_pkg::CNT_BITS-1:0]         rsp_recovery_total,
   output logic [cbd_pkg::CNT_BITS-1:0]         rsp_attempt_total,
   output logic [cbd_pkg::TIME_BITS-1:0]        rsp_degraded_time_ms,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [cbd_pkg::ADDR_BITS-1:0]        csr_paddr,
   input  logic [cbd_pkg::DATA_BITS-1:0]        csr_pwdata,
   output logic [cbd_pkg::DATA_BITS-1:0]        csr_prdata,
   output logic                                 csr_pready
);

   cbd_pkg::cfg_type    cfg_ff;
   cbd_pkg::cfg_type    cfg_in;
   logic                in_valid_ff;
   cbd_pkg::item_type   item_ff;
   logic                out_valid_ff;
   cbd_pkg::result_type result_ff;
   cbd_pkg::state_type  state_ff;
   cbd_pkg::state_type  state_in;
   cbd_pkg::result_type result_in;
   logic                advance;
   logic                csr_write;
   logic [1:0]          csr_index;

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            cbd_pkg::REG_FAIL_TH:  cfg_in.fail_th  = csr_pwdata[cbd_pkg::RUN_BITS-1:0];
            cbd_pkg::REG_SUCC_TH:  cfg_in.succ_th  = csr_pwdata[cbd_pkg::RUN_BITS-1:0];
            cbd_pkg::REG_OPEN_TMO: cfg_in.open_tmo = csr_pwdata[cbd_pkg::TMO_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         cbd_pkg::REG_FAIL_TH:  csr_prdata = cbd_pkg::DATA_BITS'(cfg_ff.fail_th);
         cbd_pkg::REG_SUCC_TH:  csr_prdata = cbd_pkg::DATA_BITS'(cfg_ff.succ_th);
         cbd_pkg::REG_OPEN_TMO: csr_prdata = cbd_pkg::DATA_BITS'(cfg_ff.open_tmo);
         default:               csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fail_th  <= cbd_pkg::run_type'(5);
         cfg_ff.succ_th  <= cbd_pkg::run_type'(3);
         cfg_ff.open_tmo <= cbd_pkg::TMO_BITS'(30000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.op    <= req_op;
         item_ff.now   <= req_now_ms;
         item_ff.cache <= req_cache_has_entries;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   cbd_next u_next (
      .cur  (state_ff),
      .item (item_ff),
      .cfg  (cfg_ff),
      .nxt  (state_in),
      .res  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.breaker        <= cbd_pkg::BRK_CLOSED;
         state_ff.level          <= cbd_pkg::LVL_NONE;
         state_ff.fail_cnt       <= '0;
         state_ff.succ_cnt       <= '0;
         state_ff.opened_time    <= '0;
         state_ff.degrade_start  <= '0;
         state_ff.trip_cnt       <= '0;
         state_ff.rec_cnt        <= '0;
         state_ff.att_cnt        <= '0;
         state_ff.degraded_total <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_breaker_state    = result_ff.breaker;
   assign rsp_level            = result_ff.level;
   assign rsp_level_changed    = result_ff.level_changed;
   assign rsp_previous_level   = result_ff.prev_level;
   assign rsp_fail_run         = result_ff.fail_run;
   assign rsp_success_run      = result_ff.succ_run;
   assign rsp_recovery_result  = result_ff.rres;
   assign rsp_trip_total       = result_ff.trip_total;
   assign rsp_recovery_total   = result_ff.rec_total;
   assign rsp_attempt_total    = result_ff.att_total;
   assign rsp_degraded_time_ms = result_ff.degraded_time;

endmodule

`default_nettype wire

@@ rtl/cbd_checker.sv @@
`default_nettype none

`include "circuit_breaker_degradation_macros.svh"

module cbd_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [1:0] rsp_breaker_state,
   input  wire logic [2:0] rsp_level,
   input  wire logic       rsp_level_changed,
   input  wire logic [2:0] rsp_previous_level,
   input  wire logic [1:0] rsp_recovery_result
);

   logic closed_ok;
   logic half_ok;
   logic open_ok;

   // level must follow the breaker state
   assign closed_ok = rsp_breaker_state == cbd_pkg::BRK_CLOSED
                      && rsp_level == cbd_pkg::LVL_NONE;
   assign half_ok   = rsp_breaker_state == cbd_pkg::BRK_HALF
                      && rsp_level == cbd_pkg::LVL_READ_ONLY;
   assign open_ok   = rsp_breaker_state == cbd_pkg::BRK_OPEN
                      && (rsp_level == cbd_pkg::LVL_CACHE_ONLY
                          || rsp_level == cbd_pkg::LVL_OFFLINE);

   `CBD_ASSERT_RST(a_reset_empty, reset, !rsp_valid)
   `CBD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `CBD_ASSERT_NOW(a_level_flag, rsp_valid, rsp_level_changed == (rsp_level != rsp_previous_level))
   `CBD_ASSERT_NOW(a_level_map, rsp_valid, closed_ok || half_ok || open_ok)
   `CBD_ASSERT_NOW(a_recovered_closed, rsp_valid && rsp_recovery_result == cbd_pkg::RR_RECOVERED, rsp_breaker_state == cbd_pkg::BRK_CLOSED)

endmodule

bind circuit_breaker_degradation cbd_checker u_cbd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_breaker_state   (rsp_breaker_state),
   .rsp_level           (rsp_level),
   .rsp_level_changed   (rsp_level_changed),
   .rsp_previous_level  (rsp_previous_level),
   .rsp_recovery_result (rsp_recovery_result)
);

`default_nettype wire
